// File: rtl/egcd_pkg.sv
package egcd_pkg;

  // Operand and result field widths
  localparam int unsigned OPND_W = 31;
  localparam int unsigned OUT_W  = 32;

  // Quotient bit counter: one restoring step per operand bit
  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_LAST_BIT = CNT_W'(OPND_W - 1);

  // Microprogram counter and step addresses
  localparam int unsigned UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_IDLE   = 3'd0;
  localparam upc_t UPC_TEST   = 3'd1;
  localparam upc_t UPC_DIV    = 3'd2;
  localparam upc_t UPC_UPDATE = 3'd3;
  localparam upc_t UPC_EMIT   = 3'd4;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_INIT,
    OP_DIV,
    OP_UPDATE,
    OP_EMIT
  } dp_op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_R_ZERO,
    COND_CNT_ZERO,
    COND_OUT_FREE
  } cond_e;

  // One control word: operation, optional gating on the condition, jump
  typedef struct packed {
    dp_op_e op;
    logic   gated;
    cond_e  cond;
    upc_t   target;
    upc_t   next;
  } ctrl_word_t;

  // Control from sequencer to datapath
  typedef struct packed {
    dp_op_e op;
    logic   fire;
  } dp_ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic r_zero;
    logic cnt_zero;
    logic out_free;
  } dp_status_t;

  // Microprogram ROM
  function automatic ctrl_word_t ucode_rom(input upc_t addr);
    ctrl_word_t w;
    unique case (addr)
      UPC_IDLE:   w = '{OP_LOAD,   1'b1, COND_IN_VALID, UPC_TEST,   UPC_IDLE};
      UPC_TEST:   w = '{OP_INIT,   1'b0, COND_R_ZERO,   UPC_EMIT,   UPC_DIV};
      UPC_DIV:    w = '{OP_DIV,    1'b0, COND_CNT_ZERO, UPC_UPDATE, UPC_DIV};
      UPC_UPDATE: w = '{OP_UPDATE, 1'b0, COND_ALWAYS,   UPC_TEST,   UPC_TEST};
      UPC_EMIT:   w = '{OP_EMIT,   1'b1, COND_OUT_FREE, UPC_IDLE,   UPC_EMIT};
      default:    w = '{OP_LOAD,   1'b1, COND_IN_VALID, UPC_TEST,   UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/egcd_seq.sv
module egcd_seq
  import egcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output dp_ctrl_t   ctrl_o
);

  upc_t       upc_q, upc_d;
  ctrl_word_t word;
  logic       cond_true;

  // Fetch the control word of the current step
  assign word = ucode_rom(upc_q);

  // Evaluate the jump condition
  always_comb begin
    unique case (word.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_IN_VALID: cond_true = in_valid_i;
      COND_R_ZERO:   cond_true = status_i.r_zero;
      COND_CNT_ZERO: cond_true = status_i.cnt_zero;
      COND_OUT_FREE: cond_true = status_i.out_free;
      default:       cond_true = 1'b0;
    endcase
  end

  // Select next step and gate the operation
  always_comb begin
    upc_d       = cond_true ? word.target : word.next;
    ctrl_o.op   = word.op;
    ctrl_o.fire = !word.gated || cond_true;
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// File: rtl/egcd_dp.sv
module egcd_dp
  import egcd_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_ctrl_t          ctrl_i,
  output dp_status_t        status_o,
  input  logic [OPND_W-1:0] first_value_i,
  input  logic [OPND_W-1:0] second_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OPND_W-1:0] divisor_o,
  output logic [OUT_W-1:0]  coef_first_o,
  output logic [OUT_W-1:0]  coef_second_o
);

  // Running remainders and coefficients
  logic [OPND_W-1:0] r_old_q, r_old_d, r_new_q, r_new_d;
  logic [WIDTH-1:0]  s_old_q, s_old_d, s_new_q, s_new_d;
  logic [WIDTH-1:0]  t_old_q, t_old_d, t_new_q, t_new_d;

  // Divider state: partial remainder, dividend shifter, quotient products
  logic [OPND_W-1:0] rem_q, rem_d, dvd_q, dvd_d;
  logic [WIDTH-1:0]  qs_q, qs_d, qt_q, qt_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [OPND_W-1:0] divisor_q, divisor_d;
  logic [OUT_W-1:0]  coef_first_q, coef_first_d, coef_second_q, coef_second_d;

  logic [OPND_W:0]   shifted;
  logic [OPND_W+1:0] trial;
  logic              q_bit;

  // One restoring division step
  always_comb begin
    shifted = {rem_q, dvd_q[OPND_W-1]};
    trial   = {1'b0, shifted} - {2'b00, r_new_q};
    q_bit   = !trial[OPND_W+1];
  end

  // Datapath operations
  always_comb begin
    r_old_d = r_old_q;
    r_new_d = r_new_q;
    s_old_d = s_old_q;
    s_new_d = s_new_q;
    t_old_d = t_old_q;
    t_new_d = t_new_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    qs_d    = qs_q;
    qt_d    = qt_q;
    cnt_d   = cnt_q;
    divisor_d     = divisor_q;
    coef_first_d  = coef_first_q;
    coef_second_d = coef_second_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    if (ctrl_i.fire) begin
      unique case (ctrl_i.op)
        OP_LOAD: begin
          r_old_d = first_value_i;
          r_new_d = second_value_i;
          s_old_d = WIDTH'(1);
          s_new_d = '0;
          t_old_d = '0;
          t_new_d = WIDTH'(1);
        end
        OP_INIT: begin
          rem_d = '0;
          dvd_d = r_old_q;
          qs_d  = '0;
          qt_d  = '0;
          cnt_d = DIV_LAST_BIT;
        end
        OP_DIV: begin
          rem_d = q_bit ? trial[OPND_W-1:0] : shifted[OPND_W-1:0];
          dvd_d = {dvd_q[OPND_W-2:0], 1'b0};
          qs_d  = {qs_q[WIDTH-2:0], 1'b0} + (q_bit ? s_new_q : '0);
          qt_d  = {qt_q[WIDTH-2:0], 1'b0} + (q_bit ? t_new_q : '0);
          cnt_d = cnt_q - CNT_W'(1);
        end
        OP_UPDATE: begin
          r_old_d = r_new_q;
          r_new_d = rem_q;
          s_old_d = s_new_q;
          s_new_d = s_old_q - qs_q;
          t_old_d = t_new_q;
          t_new_d = t_old_q - qt_q;
        end
        OP_EMIT: begin
          divisor_d     = r_old_q;
          coef_first_d  = OUT_W'($signed(s_old_q));
          coef_second_d = OUT_W'($signed(t_old_q));
          out_valid_d   = 1'b1;
        end
        default: begin
          out_valid_d = out_valid_q && !out_ready_i;
        end
      endcase
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    r_old_q <= r_old_d;
    r_new_q <= r_new_d;
    s_old_q <= s_old_d;
    s_new_q <= s_new_d;
    t_old_q <= t_old_d;
    t_new_q <= t_new_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    qs_q    <= qs_d;
    qt_q    <= qt_d;
    cnt_q   <= cnt_d;
    divisor_q     <= divisor_d;
    coef_first_q  <= coef_first_d;
    coef_second_q <= coef_second_d;
  end

  // Output request valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.r_zero   = (r_new_q == '0);
  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign divisor_o     = divisor_q;
  assign coef_first_o  = coef_first_q;
  assign coef_second_o = coef_second_q;

endmodule

// File: rtl/extended_gcd_bezout.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------
// input    | in_valid_i/in_ready_o | first_value_i, second_value_i
// output   | out_valid_o/out_ready_i | divisor_o, coef_first_o, coef_second_o
//
// One request at a time; in_ready_o is high only in the idle step.
// Each request runs k quotient steps (up to ~45) between its load and emit steps;
// each quotient step is one bit-serial restoring division, one step per operand
// bit, that also forms q*s and q*t by shift-add, plus a test and an update step.
// The result waits in an output register; a new request is taken while it waits.
// Reset (rst_ni low) returns the step counter to idle and drops output valid.
module extended_gcd_bezout
  import egcd_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OPND_W-1:0] first_value_i,
  input  logic [OPND_W-1:0] second_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OPND_W-1:0] divisor_o,
  output logic [OUT_W-1:0]  coef_first_o,
  output logic [OUT_W-1:0]  coef_second_o
);

  dp_ctrl_t   ctrl;
  dp_status_t status;

  // Microcode sequencer
  egcd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  // Remainder and coefficient datapath
  egcd_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .divisor_o      (divisor_o),
    .coef_first_o   (coef_first_o),
    .coef_second_o  (coef_second_o)
  );

  assign in_ready_o = (ctrl.op == OP_LOAD);

endmodule

// File: rtl/egcd_checker.sv
module egcd_checker
  import egcd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [OPND_W-1:0] divisor_o,
  input logic [OUT_W-1:0]  coef_first_o,
  input logic [OUT_W-1:0]  coef_second_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(divisor_o)
      && $stable(coef_first_o) && $stable(coef_second_o))
    else $error("stalled result changed");

  // Accepted request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // No result appears right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result raised too early");

  // Zero divisor only from both operands zero: coefficients one and zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (divisor_o == '0) |-> (coef_first_o == OUT_W'(1))
      && (coef_second_o == '0))
    else $error("bad coefficients for zero divisor");

endmodule

bind extended_gcd_bezout egcd_checker u_chk (.*);

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import egcd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES    = 1600;
  localparam int unsigned ITEMS_PER_PHASE = 220;
  localparam int unsigned NUM_PHASES      = 4;
  localparam int unsigned DIR_N           = 22;
  localparam int unsigned REPORT_MAX      = 10;
  localparam logic [OPND_W-1:0] OPND_MAX  = '1;

  // Idle and stall percentages per phase: none, sender, receiver, both
  localparam int unsigned SEND_IDLE [NUM_PHASES] = '{0, 58, 0, 9};
  localparam int unsigned RECV_STALL[NUM_PHASES] = '{0, 0, 58, 9};

  typedef struct packed {
    logic [OPND_W-1:0] divisor;
    logic [OUT_W-1:0]  coef_first;
    logic [OUT_W-1:0]  coef_second;
  } bezout_t;

  typedef struct packed {
    logic [OPND_W-1:0] first;
    logic [OPND_W-1:0] second;
    logic              typed;
    bezout_t           want;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [OPND_W-1:0] first_value_i;
  logic [OPND_W-1:0] second_value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [OPND_W-1:0] divisor_o;
  logic [OUT_W-1:0]  coef_first_o;
  logic [OUT_W-1:0]  coef_second_o;

  bezout_t     pending_bezout[$];
  dir_row_t    dir_tab[DIR_N];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned req_count;
  int unsigned res_count;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  extended_gcd_bezout dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .first_value_i (first_value_i),
    .second_value_i(second_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .divisor_o     (divisor_o),
    .coef_first_o  (coef_first_o),
    .coef_second_o (coef_second_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Run the extended Euclidean recurrence; coefficients wrap at 32 bits
  function automatic bezout_t predict_bezout(logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
    longint unsigned rem_old, rem_new, rem_next, quot;
    logic [OUT_W-1:0] s_old, s_new, s_next, t_old, t_new, t_next;
    bezout_t res;
    rem_old = 64'(a);
    rem_new = 64'(b);
    s_old = 32'd1;
    s_new = 32'd0;
    t_old = 32'd0;
    t_new = 32'd1;
    while (rem_new != 0) begin
      quot     = rem_old / rem_new;
      rem_next = rem_old % rem_new;
      s_next   = s_old - OUT_W'(quot) * s_new;
      t_next   = t_old - OUT_W'(quot) * t_new;
      rem_old  = rem_new;
      rem_new  = rem_next;
      s_old    = s_new;
      s_new    = s_next;
      t_old    = t_new;
      t_new    = t_next;
    end
    res.divisor     = OPND_W'(rem_old);
    res.coef_first  = s_old;
    res.coef_second = t_old;
    return res;
  endfunction

  // Hold the request until accepted, after a random number of idle cycles
  task automatic send_request(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b,
                              input logic typed, input bezout_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    first_value_i  <= a;
    second_value_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_bezout.push_back(typed ? want : predict_bezout(a, b));
    req_count++;
  endtask

  // Check each accepted result against the oldest expectation, then pick ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_count++;
      if (pending_bezout.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("[%0t] unexpected result: gcd=%0d s=%0d t=%0d", $realtime,
                   divisor_o, $signed(coef_first_o), $signed(coef_second_o));
      end else begin
        bezout_t exp_res;
        exp_res = pending_bezout.pop_front();
        if (exp_res.divisor !== divisor_o || exp_res.coef_first !== coef_first_o ||
            exp_res.coef_second !== coef_second_o) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("[%0t] mismatch: expected gcd=%0d s=%0d t=%0d, got gcd=%0d s=%0d t=%0d",
                     $realtime, exp_res.divisor, $signed(exp_res.coef_first),
                     $signed(exp_res.coef_second), divisor_o, $signed(coef_first_o),
                     $signed(coef_second_o));
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort when no request and no result moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_bezout.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned kind, g, n;
    logic [OPND_W-1:0] a, b, fa, fb, tmp;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    first_value_i  = '0;
    second_value_i = '0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    req_count      = 0;
    res_count      = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;

    // Directed rows: zero operands, extremes, swapped order, worst-case step count
    dir_tab = '{
      '{31'd0,          31'd0,          1'b1, '{31'd0,    32'd1, 32'd0}},
      '{OPND_MAX,       31'd0,          1'b1, '{OPND_MAX, 32'd1, 32'd0}},
      '{31'd1,          31'd0,          1'b1, '{31'd1,    32'd1, 32'd0}},
      '{31'd0,          OPND_MAX,       1'b1, '{OPND_MAX, 32'd0, 32'd1}},
      '{31'd0,          31'd1,          1'b1, '{31'd1,    32'd0, 32'd1}},
      '{OPND_MAX,       OPND_MAX,       1'b1, '{OPND_MAX, 32'd0, 32'd1}},
      '{31'd1,          31'd1,          1'b1, '{31'd1,    32'd0, 32'd1}},
      '{31'd240,        31'd46,         1'b0, '0},
      '{31'd46,         31'd240,        1'b0, '0},
      '{31'd12,         31'd18,         1'b0, '0},
      '{31'd17,         31'd5,          1'b0, '0},
      '{31'd1836311903, 31'd1134903170, 1'b0, '0},
      '{31'd1134903170, 31'd1836311903, 1'b0, '0},
      '{OPND_MAX,       OPND_MAX - OPND_W'(1), 1'b0, '0},
      '{OPND_MAX - OPND_W'(1), OPND_MAX, 1'b0, '0},
      '{OPND_MAX,       31'd1,          1'b0, '0},
      '{31'd1,          OPND_MAX,       1'b0, '0},
      '{31'h4000_0000,  31'h2000_0000,  1'b0, '0},
      '{31'h5555_5555,  31'h2AAA_AAAA,  1'b0, '0},
      '{OPND_MAX,       31'd2147483629, 1'b0, '0},
      '{31'd1000000007, 31'd998244353,  1'b0, '0},
      '{31'd1073741823, 31'd715827882,  1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++)
      send_request(dir_tab[i].first, dir_tab[i].second, dir_tab[i].typed, dir_tab[i].want);

    // Random requests, one idling profile per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        kind = $urandom_range(19);
        if (kind < 8) begin
          a = OPND_W'($urandom);
          b = OPND_W'($urandom);
        end else if (kind < 12) begin
          a = OPND_W'($urandom_range(255));
          b = OPND_W'($urandom_range(255));
        end else if (kind < 15) begin
          // shared factor, so the gcd is large
          g = $urandom_range(1, 32767);
          a = OPND_W'(g * $urandom_range(32767));
          b = OPND_W'(g * $urandom_range(32767));
        end else if (kind < 17) begin
          // adjacent Fibonacci numbers give the longest quotient chains
          n  = $urandom_range(2, 46);
          fa = '0;
          fb = 31'd1;
          repeat (n - 1) begin
            tmp = fa + fb;
            fa  = fb;
            fb  = tmp;
          end
          a = $urandom_range(1) ? fb : fa;
          b = (a == fb) ? fa : fb;
        end else if (kind == 17) begin
          a = OPND_W'($urandom);
          b = '0;
          if ($urandom_range(1)) begin
            b = a;
            a = '0;
          end
        end else if (kind == 18) begin
          a = OPND_MAX - OPND_W'($urandom_range(1023));
          b = OPND_MAX - OPND_W'($urandom_range(1023));
        end else begin
          a = OPND_W'($urandom);
          b = a;
        end
        send_request(a, b, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then give a stray result time to show up
    while (pending_bezout.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d gcd requests sent (directed rows, random, shared-factor, Fibonacci,",
             req_count);
    $display("zero and near-max operands) over four idle/stall profiles; %0d results, %0d bad",
             res_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/egcd_pkg.sv
rtl/egcd_seq.sv
rtl/egcd_dp.sv
rtl/extended_gcd_bezout.sv
rtl/egcd_checker.sv
verif/tb.sv
